### design/swmp_pkg.sv
`timescale 1ns / 1ps

package swmp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 9;
    localparam int SHIFT_W    = 8;
    localparam int CFG_DIM_W  = 9;
    localparam int CFG_LIM_W  = 3;
    localparam int CFG_STEP_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Product of a query cell and the step, before the range check.
    localparam int PROD_W     = POS_W + CFG_STEP_W;

    // Window coordinates reach up to the shift limit beyond either edge of the image.
    localparam int COORD_W    = 11;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_SHIFT  = 7;

    localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_WIDTH    = 9'd256;
    localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_HEIGHT   = 9'd256;
    localparam logic [CFG_LIM_W-1:0]  RST_SHIFT_LIMIT    = 3'd3;
    localparam logic [CFG_STEP_W-1:0] RST_SUBSAMPLE_STEP = 5'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSAMPLE_STEP = 2'd3;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

### design/swmp_ram.sv
`timescale 1ns / 1ps

module swmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/subsampled_window_max_pool_top.sv
`timescale 1ns / 1ps

// Max pooling with argmax over a stored response map. A load beat (tuser 0) writes one
// signed 16-bit response at 1-based pixel (pos_x, pos_y); loads outside the configured
// image are dropped. A query beat (tuser 1) names a 1-based cell of the subsampled map and
// yields one result beat: the maximum over the (2L+1) by (2L+1) window centred at the cell
// times the step, the 1-based window position of its first occurrence (column outer, row
// inner), and an error flag for cells outside the map. The window is scanned one pixel per
// clock through the single read port of the pixel memory, so s_tready stays low from an
// accepted query until its result enters the output register; an out-of-map query skips
// the scan. A finished result waits in the output register while loads go on.
// Pixels must be loaded before a query reads them; the memory is not cleared at reset.

module subsampled_window_max_pool_top
#(
    parameter int MAX_WIDTH  = swmp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = swmp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_SHIFT  = swmp_pkg::DEF_MAX_SHIFT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [swmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swmp_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: pos_x[8:0], pos_y[17:9], sample_value[33:18], zero fill.
    input  logic [swmp_pkg::S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: mode.
    input  logic                            s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: max_value[15:0], best_shift[23:16].
    output logic [swmp_pkg::M_TDATA_W-1:0]  m_tdata,
    // Fields from bit 0: query_error.
    output logic                            m_tuser
);

    import swmp_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [CFG_DIM_W-1:0]  image_width_reg;
    logic [CFG_DIM_W-1:0]  image_height_reg;
    logic [CFG_LIM_W-1:0]  shift_limit_reg;
    logic [CFG_STEP_W-1:0] subsample_step_reg;

    logic [CFG_DIM_W-1:0]  w_eff;
    logic [CFG_DIM_W-1:0]  h_eff;
    logic [CFG_LIM_W-1:0]  lim_eff;
    logic [CFG_STEP_W-1:0] step_eff;

    logic [POS_W-1:0]    in_x;
    logic [POS_W-1:0]    in_y;
    logic [SAMPLE_W-1:0] in_value;
    logic                in_accept;
    logic                load_inside;

    logic [POS_W-1:0] qx_reg;
    logic [POS_W-1:0] qy_reg;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
    logic             query_bad;
    coord_t           cx;
    coord_t           cy;
    coord_t           lim_c;

    coord_t wx_reg;
    coord_t wy_reg;
    coord_t wy_lo_reg;
    coord_t wx_hi_reg;
    coord_t wy_hi_reg;
    coord_t w_c;
    coord_t h_c;
    logic   scan_inside;
    logic   scan_last;
    logic [SHIFT_W-1:0] pos_reg;
    logic [SHIFT_W-1:0] pos_next;

    logic               rd_valid_reg;
    logic [SHIFT_W-1:0] rd_pos_reg;
    logic [SAMPLE_W-1:0] rd_data;
    logic               take_new;

    sample_t            best_reg;
    logic [SHIFT_W-1:0] best_pos_reg;
    logic               found_reg;
    logic               err_reg;

    logic                 m_tvalid_reg;
    logic [SAMPLE_W-1:0]  out_value_reg;
    logic [SHIFT_W-1:0]   out_shift_reg;
    logic                 out_error_reg;
    logic                 out_load;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= RST_IMAGE_WIDTH;
            image_height_reg   <= RST_IMAGE_HEIGHT;
            shift_limit_reg    <= RST_SHIFT_LIMIT;
            subsample_step_reg <= RST_SUBSAMPLE_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data;
                REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data;
                REG_SHIFT_LIMIT:    shift_limit_reg    <= cfg_data[CFG_LIM_W-1:0];
                REG_SUBSAMPLE_STEP: subsample_step_reg <= cfg_data[CFG_STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_eff    = (32'(image_width_reg) > MAX_WIDTH) ? CFG_DIM_W'(MAX_WIDTH)
                                                         : image_width_reg;
    assign h_eff    = (32'(image_height_reg) > MAX_HEIGHT) ? CFG_DIM_W'(MAX_HEIGHT)
                                                           : image_height_reg;
    assign lim_eff  = (32'(shift_limit_reg) > MAX_SHIFT) ? CFG_LIM_W'(MAX_SHIFT)
                                                         : shift_limit_reg;
    assign step_eff = (subsample_step_reg == '0) ? CFG_STEP_W'(1) : subsample_step_reg;

    assign in_x     = s_tdata[POS_W-1:0];
    assign in_y     = s_tdata[2*POS_W-1:POS_W];
    assign in_value = s_tdata[2*POS_W+SAMPLE_W-1:2*POS_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign load_inside = (in_x != '0) && (in_x <= w_eff) && (in_y != '0) && (in_y <= h_eff);
    assign wr_en   = in_accept && (s_tuser == MODE_LOAD) && load_inside;
    assign wr_addr = ADDR_W'(ADDR_W'(in_y - POS_W'(1)) * ADDR_W'(MAX_WIDTH))
                   + ADDR_W'(in_x - POS_W'(1));

    // A nonzero cell lies in the subsampled map exactly when cell * step does not pass the edge.
    assign prod_x    = PROD_W'(qx_reg) * PROD_W'(step_eff);
    assign prod_y    = PROD_W'(qy_reg) * PROD_W'(step_eff);
    assign query_bad = (qx_reg == '0) || (qy_reg == '0)
                    || (prod_x > PROD_W'(w_eff)) || (prod_y > PROD_W'(h_eff));
    assign cx        = $signed(COORD_W'(prod_x));
    assign cy        = $signed(COORD_W'(prod_y));
    assign lim_c     = $signed(COORD_W'(lim_eff));

    assign w_c = $signed(COORD_W'(w_eff));
    assign h_c = $signed(COORD_W'(h_eff));
    assign scan_inside = (wx_reg > coord_t'(0)) && (wx_reg <= w_c)
                      && (wy_reg > coord_t'(0)) && (wy_reg <= h_c);
    assign scan_last   = (wx_reg == wx_hi_reg) && (wy_reg == wy_hi_reg);
    assign pos_next    = pos_reg + SHIFT_W'(1);

    assign rd_en   = (state_reg == S_SCAN) && scan_inside;
    assign rd_addr = ADDR_W'(ADDR_W'($unsigned(wy_reg - coord_t'(1))) * ADDR_W'(MAX_WIDTH))
                   + ADDR_W'($unsigned(wx_reg - coord_t'(1)));

    assign take_new = rd_valid_reg && (!found_reg || ($signed(rd_data) > best_reg));

    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    swmp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_pixel_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            qx_reg        <= '0;
            qy_reg        <= '0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            wy_lo_reg     <= '0;
            wx_hi_reg     <= '0;
            wy_hi_reg     <= '0;
            pos_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            rd_pos_reg    <= '0;
            best_reg      <= '0;
            best_pos_reg  <= '0;
            found_reg     <= 1'b0;
            err_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            out_value_reg <= '0;
            out_shift_reg <= '0;
            out_error_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end

            rd_valid_reg <= rd_en;
            rd_pos_reg   <= pos_next;
            if (take_new)
            begin
                best_reg     <= $signed(rd_data);
                best_pos_reg <= rd_pos_reg;
                found_reg    <= 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && (s_tuser == MODE_QUERY))
                    begin
                        qx_reg    <= in_x;
                        qy_reg    <= in_y;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    pos_reg   <= '0;
                    found_reg <= 1'b0;
                    wx_reg    <= cx - lim_c;
                    wy_reg    <= cy - lim_c;
                    wy_lo_reg <= cy - lim_c;
                    wx_hi_reg <= cx + lim_c;
                    wy_hi_reg <= cy + lim_c;
                    if (query_bad)
                    begin
                        best_reg     <= '0;
                        best_pos_reg <= '0;
                        err_reg      <= 1'b1;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        best_reg     <= sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}});
                        best_pos_reg <= '0;
                        err_reg      <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    pos_reg <= pos_next;
                    if (scan_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else if (wy_reg == wy_hi_reg)
                    begin
                        wy_reg <= wy_lo_reg;
                        wx_reg <= wx_reg + coord_t'(1);
                    end
                    else
                    begin
                        wy_reg <= wy_reg + coord_t'(1);
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        m_tvalid_reg  <= 1'b1;
                        out_value_reg <= best_reg;
                        out_shift_reg <= best_pos_reg;
                        out_error_reg <= err_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_shift_reg, out_value_reg};
    assign m_tuser  = out_error_reg;

    a_error_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("Out-of-map result carries a nonzero value or position.");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_IDLE))
        else $error("Pixel memory written while a query is in progress.");

    a_valid_query_found: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && !err_reg) |-> (found_reg && (best_pos_reg != '0)))
        else $error("In-map query finished without reading any pixel.");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("Result beat raised outside the completion state.");

endmodule

### dv/tb_subsampled_window_max_pool_top.sv
`timescale 1ns / 1ps

module tb_subsampled_window_max_pool_top;
    import swmp_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_GAP       = 17;
    localparam int POS_MAX       = (1 << POS_W) - 1;
    localparam int PIXELS        = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    typedef struct {
        sample_t            value;
        logic [SHIFT_W-1:0] shift;
        logic               err;
    } pool_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    sample_t      pixel_mem [PIXELS];
    bit           pixel_known [PIXELS];
    int           img_w;
    int           img_h;
    int           half_win;
    int           step_raw;
    pool_result_t pooled_expect [$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           send_quiet = 0;
    int           recv_quiet = 0;
    int           recv_hold = 0;
    int           last_ox = 0;
    int           last_oy = 0;

    always #4 clk = ~clk;

    subsampled_window_max_pool_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    function automatic int eff_w();
        return (img_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : img_w;
    endfunction

    function automatic int eff_h();
        return (img_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : img_h;
    endfunction

    function automatic int eff_step();
        return (step_raw == 0) ? 1 : step_raw;
    endfunction

    function automatic int eff_half();
        return (half_win > DEF_MAX_SHIFT) ? DEF_MAX_SHIFT : half_win;
    endfunction

    function automatic int map_cols();
        return eff_w() / eff_step();
    endfunction

    function automatic int map_rows();
        return eff_h() / eff_step();
    endfunction

    function automatic bit in_image(input int x, input int y);
        return x >= 1 && x <= eff_w() && y >= 1 && y <= eff_h();
    endfunction

    function automatic bit in_map(input int ox, input int oy);
        return ox >= 1 && oy >= 1 && ox <= map_cols() && oy <= map_rows();
    endfunction

    function automatic int pixel_addr(input int x, input int y);
        return (x - 1) + (y - 1) * DEF_MAX_WIDTH;
    endfunction

    function automatic pool_result_t pool_window(input int ox, input int oy);
        pool_result_t r;
        int           cx;
        int           cy;
        int           n;
        int           lim;
        bit           hit;
        sample_t      v;
        r.value = sample_t'(0);
        r.shift = '0;
        r.err   = 1'b1;
        if (!in_map(ox, oy))
            return r;
        r.value = sample_t'(-32768);
        r.err   = 1'b0;
        cx  = ox * eff_step();
        cy  = oy * eff_step();
        lim = eff_half();
        n   = 0;
        hit = 1'b0;
        for (int lx = -lim; lx <= lim; lx++)
        begin
            for (int ly = -lim; ly <= lim; ly++)
            begin
                n++;
                if (in_image(cx + lx, cy + ly))
                begin
                    v = pixel_mem[pixel_addr(cx + lx, cy + ly)];
                    if (!hit || v > r.value)
                    begin
                        r.value = v;
                        r.shift = SHIFT_W'(n);
                        hit     = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic int draw_gap(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            quiet = $urandom_range(10, 40);
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic sample_t pick_sample();
        int t;
        if ($urandom_range(0, 3) == 0)
        begin
            t = $urandom_range(0, 6);
            return sample_t'(t - 3);
        end
        return sample_t'($urandom());
    endfunction

    task automatic send_item(input logic mode, input int x, input int y, input sample_t v);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= S_TDATA_W'({v, POS_W'(y), POS_W'(x)});
        do @(posedge clk); while (s_tready !== 1'b1);
        if (mode == MODE_LOAD)
        begin
            if (in_image(x, y))
            begin
                pixel_mem[pixel_addr(x, y)]   = v;
                pixel_known[pixel_addr(x, y)] = 1'b1;
            end
        end
        else
            pooled_expect.push_back(pool_window(x, y));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pooled_expect.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_config(input int w, input int h, input int l, input int s);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        @(negedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h);
        @(negedge clk);
        cfg_index <= REG_SHIFT_LIMIT;
        cfg_data  <= CFG_DATA_W'(l);
        @(negedge clk);
        cfg_index <= REG_SUBSAMPLE_STEP;
        cfg_data  <= CFG_DATA_W'(s);
        @(negedge clk);
        cfg_we <= 1'b0;
        img_w    = w;
        img_h    = h;
        half_win = l;
        step_raw = s;
        foreach (pixel_known[i])
            pixel_known[i] = 1'b0;
    endtask

    // Every in-image pixel a query will read must have been loaded first.
    task automatic load_window(input int ox, input int oy);
        int cx;
        int cy;
        int lim;
        cx  = ox * eff_step();
        cy  = oy * eff_step();
        lim = eff_half();
        for (int lx = -lim; lx <= lim; lx++)
        begin
            for (int ly = -lim; ly <= lim; ly++)
            begin
                if (in_image(cx + lx, cy + ly) && !pixel_known[pixel_addr(cx + lx, cy + ly)])
                    send_item(MODE_LOAD, cx + lx, cy + ly, pick_sample());
            end
        end
    endtask

    task automatic run_phase(input int w, input int h, input int l, input int s,
                             input int n_queries);
        int done;
        int pick;
        int x;
        int y;
        done = 0;
        wait_idle();
        program_config(w, h, l, s);
        last_ox = 0;
        while (done < n_queries)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5 && map_cols() > 0 && map_rows() > 0)
            begin
                if (last_ox != 0 && $urandom_range(0, 4) != 0)
                begin
                    x = last_ox + $urandom_range(0, 2) - 1;
                    y = last_oy + $urandom_range(0, 2) - 1;
                end
                else
                begin
                    x = $urandom_range(1, map_cols());
                    y = $urandom_range(1, map_rows());
                end
                x = (x < 1) ? 1 : (x > map_cols()) ? map_cols() : x;
                y = (y < 1) ? 1 : (y > map_rows()) ? map_rows() : y;
                load_window(x, y);
                send_item(MODE_QUERY, x, y, pick_sample());
                last_ox = x;
                last_oy = y;
                done++;
            end
            else if (pick < 7)
            begin
                x = $urandom_range(0, POS_MAX);
                y = $urandom_range(0, POS_MAX);
                case ($urandom_range(0, 3))
                    0: x = 0;
                    1: y = 0;
                    2: x = $urandom_range(map_cols() + 1, POS_MAX);
                    default: y = $urandom_range(map_rows() + 1, POS_MAX);
                endcase
                if (in_map(x, y))
                    x = 0;
                send_item(MODE_QUERY, x, y, pick_sample());
                done++;
            end
            else if (pick < 9 && eff_w() > 0 && eff_h() > 0)
                send_item(MODE_LOAD, $urandom_range(1, eff_w()), $urandom_range(1, eff_h()),
                          pick_sample());
            else
            begin
                x = $urandom_range(0, POS_MAX);
                y = $urandom_range(0, POS_MAX);
                if (in_image(x, y))
                begin
                    if ($urandom_range(0, 1) == 0)
                        x = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(eff_w() + 1, POS_MAX);
                    else
                        y = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(eff_h() + 1, POS_MAX);
                end
                send_item(MODE_LOAD, x, y, pick_sample());
            end
        end
    endtask

    task automatic test_directed();
        sample_t win_vals [9] = '{3, -32768, -1, 7, 0, 7, -20, 5, -32768};
        int      k;
        k = 0;
        program_config(DEF_MAX_WIDTH, DEF_MAX_HEIGHT, 1, 2);
        for (int x = 1; x <= 3; x++)
        begin
            for (int y = 1; y <= 3; y++)
            begin
                send_item(MODE_LOAD, x, y, win_vals[k]);
                k++;
            end
        end
        send_item(MODE_QUERY, 1, 1, 0);
        // Loads just past the right, bottom and left edges must not alias onto the window.
        send_item(MODE_LOAD, DEF_MAX_WIDTH + 1, 1, 32767);
        send_item(MODE_LOAD, 1, DEF_MAX_HEIGHT + 1, 32767);
        send_item(MODE_LOAD, 0, 2, 32767);
        send_item(MODE_QUERY, 1, 1, 0);
        send_item(MODE_LOAD, 2, 2, 32767);
        send_item(MODE_QUERY, 1, 1, 0);
        send_item(MODE_QUERY, 0, 1, 0);
        send_item(MODE_QUERY, 1, 0, 0);
        send_item(MODE_QUERY, DEF_MAX_WIDTH / 2 + 1, 1, 0);
        send_item(MODE_QUERY, POS_MAX, POS_MAX, -1);
        for (int x = DEF_MAX_WIDTH - 1; x <= DEF_MAX_WIDTH; x++)
        begin
            for (int y = DEF_MAX_HEIGHT - 1; y <= DEF_MAX_HEIGHT; y++)
                send_item(MODE_LOAD, x, y, -32768);
        end
        send_item(MODE_QUERY, DEF_MAX_WIDTH / 2, DEF_MAX_HEIGHT / 2, 0);
    endtask

    task automatic test_random_small();
        for (int i = 0; i < 5; i++)
            run_phase($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(0, 7),
                      $urandom_range(0, 4), 30);
    endtask

    task automatic test_config_extremes();
        run_phase(POS_MAX, POS_MAX, 4, 1, 10);
        run_phase(DEF_MAX_WIDTH, DEF_MAX_HEIGHT, 2, 31, 10);
        run_phase(0, 16, 5, 0, 8);
        run_phase(7, 0, 1, 1, 6);
        run_phase(1, 1, 7, 0, 8);
        run_phase(32, 32, 0, 16, 10);
        run_phase(20, 3, 7, 1, 15);
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_hold > 0)
            begin
                m_tready <= 1'b0;
                recv_hold--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pool_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            recv_hold = draw_gap(recv_quiet);
            if (pooled_expect.size() == 0)
            begin
                $error("result beat with no query pending");
                mismatches++;
            end
            else
            begin
                want = pooled_expect.pop_front();
                if (m_tdata[SAMPLE_W-1:0] !== want.value)
                begin
                    $error("max_value: expected %0d, got %0d", want.value,
                           $signed(m_tdata[SAMPLE_W-1:0]));
                    mismatches++;
                end
                if (m_tdata[SAMPLE_W +: SHIFT_W] !== want.shift)
                begin
                    $error("best_shift: expected %0d, got %0d", want.shift,
                           m_tdata[SAMPLE_W +: SHIFT_W]);
                    mismatches++;
                end
                if (m_tuser !== want.err)
                begin
                    $error("query_error: expected %0d, got %0d", want.err, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_LOAD;
        img_w     = RST_IMAGE_WIDTH;
        img_h     = RST_IMAGE_HEIGHT;
        half_win  = RST_SHIFT_LIMIT;
        step_raw  = RST_SUBSAMPLE_STEP;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_small();
        test_config_extremes();
        wait_idle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
design/swmp_pkg.sv
design/swmp_ram.sv
design/subsampled_window_max_pool_top.sv
dv/tb_subsampled_window_max_pool_top.sv
